/* src/mtd_pkg.sv */
package mtd_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [3:0] t_kind;

    localparam t_kind K_NIL        = 4'd0;
    localparam t_kind K_FALSE      = 4'd1;
    localparam t_kind K_TRUE       = 4'd2;
    localparam t_kind K_UINT       = 4'd3;
    localparam t_kind K_SINT       = 4'd4;
    localparam t_kind K_F32        = 4'd5;
    localparam t_kind K_F64        = 4'd6;
    localparam t_kind K_STR        = 4'd7;
    localparam t_kind K_BIN        = 4'd8;
    localparam t_kind K_ARRAY      = 4'd9;
    localparam t_kind K_MAP        = 4'd10;
    localparam t_kind K_PAYLOAD    = 4'd11;
    localparam t_kind K_INVALID    = 4'd12;
    localparam t_kind K_TRUNC      = 4'd13;
    // signed integer waiting for its first byte to pick the sign fill
    localparam t_kind K_SINT_FIRST = 4'd15;

    // type codes
    localparam logic [7:0] C_POSFIX_LO = 8'h00;
    localparam logic [7:0] C_POSFIX_HI = 8'h7f;
    localparam logic [7:0] C_FIXMAP_LO = 8'h80;
    localparam logic [7:0] C_FIXMAP_HI = 8'h8f;
    localparam logic [7:0] C_FIXARR_LO = 8'h90;
    localparam logic [7:0] C_FIXARR_HI = 8'h9f;
    localparam logic [7:0] C_FIXSTR_LO = 8'ha0;
    localparam logic [7:0] C_FIXSTR_HI = 8'hbf;
    localparam logic [7:0] C_NIL       = 8'hc0;
    localparam logic [7:0] C_FALSE     = 8'hc2;
    localparam logic [7:0] C_TRUE      = 8'hc3;
    localparam logic [7:0] C_BIN8      = 8'hc4;
    localparam logic [7:0] C_BIN16     = 8'hc5;
    localparam logic [7:0] C_BIN32     = 8'hc6;
    localparam logic [7:0] C_FLOAT32   = 8'hca;
    localparam logic [7:0] C_FLOAT64   = 8'hcb;
    localparam logic [7:0] C_UINT8     = 8'hcc;
    localparam logic [7:0] C_UINT16    = 8'hcd;
    localparam logic [7:0] C_UINT32    = 8'hce;
    localparam logic [7:0] C_UINT64    = 8'hcf;
    localparam logic [7:0] C_INT8      = 8'hd0;
    localparam logic [7:0] C_INT16     = 8'hd1;
    localparam logic [7:0] C_INT32     = 8'hd2;
    localparam logic [7:0] C_INT64     = 8'hd3;
    localparam logic [7:0] C_STR8      = 8'hd9;
    localparam logic [7:0] C_STR16     = 8'hda;
    localparam logic [7:0] C_STR32     = 8'hdb;
    localparam logic [7:0] C_ARRAY16   = 8'hdc;
    localparam logic [7:0] C_ARRAY32   = 8'hdd;
    localparam logic [7:0] C_MAP16     = 8'hde;
    localparam logic [7:0] C_MAP32     = 8'hdf;
    localparam logic [7:0] C_NEGFIX_LO = 8'he0;
    localparam logic [7:0] C_NEGFIX_HI = 8'hff;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_ERROR   = 4'b1000
    } t_phase;

    // one queue entry: the byte's token, optionally followed by a truncated token
    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic        add_trunc;
    } t_entry;

endpackage

/* src/mtd_stream_if.sv */
interface mtd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source(output valid, output data_byte, output end_of_buffer, input ready);
    modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface mtd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic        last_result;

    modport source(output valid, output token_kind, output token_value,
                   output last_result, input ready);
    modport sink(input valid, input token_kind, input token_value,
                 input last_result, output ready);
endinterface

/* src/mtd_front.sv */
module mtd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mtd_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output mtd_pkg::t_entry o_entry
);
    import mtd_pkg::*;

    t_phase      r_phase, n_phase;
    t_kind       r_pk, n_pk;
    logic [3:0]  r_hbl, n_hbl;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_pl, n_pl;

    logic        emit_v;
    t_kind       emit_kind;
    logic [63:0] emit_value;
    logic        trunc;
    logic        accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic [7:0]  b;
        logic [63:0] acc_base;
        logic [3:0]  hbl_dec;
        t_kind       kind_eff;

        b          = i_in.data_byte;
        n_phase    = r_phase;
        n_pk       = r_pk;
        n_hbl      = r_hbl;
        n_acc      = r_acc;
        n_pl       = r_pl;
        emit_v     = 1'b0;
        emit_kind  = K_NIL;
        emit_value = '0;
        trunc      = 1'b0;
        acc_base   = r_acc;
        hbl_dec    = '0;
        kind_eff   = r_pk;

        unique case (r_phase)
            PH_IDLE: begin
                unique case (b) inside
                    [C_POSFIX_LO:C_POSFIX_HI]: begin
                        emit_v = 1'b1; emit_kind = K_UINT; emit_value = {56'd0, b};
                    end
                    [C_FIXMAP_LO:C_FIXMAP_HI]: begin
                        emit_v = 1'b1; emit_kind = K_MAP; emit_value = {60'd0, b[3:0]};
                    end
                    [C_FIXARR_LO:C_FIXARR_HI]: begin
                        emit_v = 1'b1; emit_kind = K_ARRAY; emit_value = {60'd0, b[3:0]};
                    end
                    [C_FIXSTR_LO:C_FIXSTR_HI]: begin
                        emit_v = 1'b1; emit_kind = K_STR; emit_value = {59'd0, b[4:0]};
                        if (b[4:0] != 5'd0) begin
                            n_phase = PH_PAYLOAD;
                            n_pl    = {27'd0, b[4:0]};
                        end
                    end
                    [C_NEGFIX_LO:C_NEGFIX_HI]: begin
                        emit_v = 1'b1; emit_kind = K_SINT; emit_value = {56'hff_ffff_ffff_ffff, b};
                    end
                    C_NIL: begin
                        emit_v = 1'b1; emit_kind = K_NIL;
                    end
                    C_FALSE: begin
                        emit_v = 1'b1; emit_kind = K_FALSE;
                    end
                    C_TRUE: begin
                        emit_v = 1'b1; emit_kind = K_TRUE;
                    end
                    C_BIN8, C_BIN16, C_BIN32: begin
                        n_phase = PH_HEADER; n_pk = K_BIN; n_acc = '0;
                        n_hbl = 4'd1 << b[1:0];
                    end
                    C_FLOAT32: begin
                        n_phase = PH_HEADER; n_pk = K_F32; n_acc = '0; n_hbl = 4'd4;
                    end
                    C_FLOAT64: begin
                        n_phase = PH_HEADER; n_pk = K_F64; n_acc = '0; n_hbl = 4'd8;
                    end
                    C_UINT8, C_UINT16, C_UINT32, C_UINT64: begin
                        n_phase = PH_HEADER; n_pk = K_UINT; n_acc = '0;
                        n_hbl = 4'd1 << b[1:0];
                    end
                    C_INT8, C_INT16, C_INT32, C_INT64: begin
                        n_phase = PH_HEADER; n_pk = K_SINT_FIRST; n_acc = '0;
                        n_hbl = 4'd1 << b[1:0];
                    end
                    C_STR8: begin
                        n_phase = PH_HEADER; n_pk = K_STR; n_acc = '0; n_hbl = 4'd1;
                    end
                    C_STR16: begin
                        n_phase = PH_HEADER; n_pk = K_STR; n_acc = '0; n_hbl = 4'd2;
                    end
                    C_STR32: begin
                        n_phase = PH_HEADER; n_pk = K_STR; n_acc = '0; n_hbl = 4'd4;
                    end
                    C_ARRAY16: begin
                        n_phase = PH_HEADER; n_pk = K_ARRAY; n_acc = '0; n_hbl = 4'd2;
                    end
                    C_ARRAY32: begin
                        n_phase = PH_HEADER; n_pk = K_ARRAY; n_acc = '0; n_hbl = 4'd4;
                    end
                    C_MAP16: begin
                        n_phase = PH_HEADER; n_pk = K_MAP; n_acc = '0; n_hbl = 4'd2;
                    end
                    C_MAP32: begin
                        n_phase = PH_HEADER; n_pk = K_MAP; n_acc = '0; n_hbl = 4'd4;
                    end
                    default: begin
                        // ext, fixext and the never-used code
                        emit_v = 1'b1; emit_kind = K_INVALID;
                        n_phase = PH_ERROR;
                    end
                endcase
            end
            PH_HEADER: begin
                if (r_pk == K_SINT_FIRST) begin
                    acc_base = {64{b[7]}};
                    kind_eff = K_SINT;
                end
                n_pk    = kind_eff;
                n_acc   = {acc_base[55:0], b};
                hbl_dec = (r_hbl != 4'd0) ? r_hbl - 4'd1 : 4'd0;
                n_hbl   = hbl_dec;
                if (hbl_dec == 4'd0) begin
                    emit_v    = 1'b1;
                    emit_kind = kind_eff;
                    if (kind_eff == K_STR || kind_eff == K_BIN) begin
                        emit_value = {32'd0, n_acc[31:0]};
                        if (n_acc[31:0] != 32'd0) begin
                            n_phase = PH_PAYLOAD;
                            n_pl    = n_acc[31:0];
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        emit_value = n_acc;
                        n_phase    = PH_IDLE;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit_v     = 1'b1;
                emit_kind  = K_PAYLOAD;
                emit_value = {56'd0, b};
                n_pl       = r_pl - 32'd1;
                if (n_pl == 32'd0) n_phase = PH_IDLE;
            end
            PH_ERROR: begin
                // drop bytes until the buffer ends
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (i_in.end_of_buffer) begin
            trunc   = (n_phase == PH_HEADER) || (n_phase == PH_PAYLOAD);
            n_phase = PH_IDLE;
            n_pk    = K_NIL;
            n_hbl   = '0;
            n_acc   = '0;
            n_pl    = '0;
        end
    end

    always_comb begin
        o_push = accept && (emit_v || trunc);
        if (emit_v) begin
            o_entry.kind      = emit_kind;
            o_entry.value     = emit_value;
            o_entry.add_trunc = trunc;
        end else begin
            o_entry.kind      = K_TRUNC;
            o_entry.value     = '0;
            o_entry.add_trunc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pk    <= K_NIL;
            r_hbl   <= '0;
            r_acc   <= '0;
            r_pl    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pk    <= n_pk;
            r_hbl   <= n_hbl;
            r_acc   <= n_acc;
            r_pl    <= n_pl;
        end
    end

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_pl != 32'd0)
        else $error("payload phase with zero bytes left");

    a_header_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_hbl != 4'd0)
        else $error("header phase with zero bytes left");

    a_eob_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.end_of_buffer |=> r_phase == PH_IDLE && r_acc == 64'd0)
        else $error("end of buffer did not return to idle");

endmodule

/* src/mtd_fifo.sv */
module mtd_fifo #(
    parameter int DEPTH = mtd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtd_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output mtd_pkg::t_entry o_data,
    output logic            o_empty
);
    import mtd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not follow push");

endmodule

/* src/mtd_back.sv */
module mtd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtd_pkg::t_entry i_data,
    input  logic            i_empty,
    output logic            o_pop,
    mtd_out_if.source       o_out
);
    import mtd_pkg::*;

    logic        r_valid;
    t_kind       r_kind;
    logic [63:0] r_value;
    logic        r_last;
    logic        r_pend;
    logic        load;

    assign load  = !r_valid || o_out.ready;
    assign o_pop = load && !r_pend && !i_empty;

    assign o_out.valid       = r_valid;
    assign o_out.token_kind  = r_kind;
    assign o_out.token_value = r_value;
    assign o_out.last_result = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_pend  <= !i_empty && i_data.add_trunc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                // second beat of the entry
                r_kind  <= K_TRUNC;
                r_value <= '0;
                r_last  <= 1'b1;
            end else begin
                r_kind  <= i_data.kind;
                r_value <= i_data.value;
                r_last  <= !i_data.add_trunc;
            end
        end
    end

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid && !r_last)
        else $error("truncated token pending without a held first beat");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == K_TRUNC |-> r_last)
        else $error("truncated token not marked last");

    a_trunc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && o_out.ready |=> r_valid && r_kind == K_TRUNC && !r_pend)
        else $error("truncated token did not follow its first beat");

endmodule

/* src/msgpack_token_decoder_core.sv */
// MessagePack token decoder. Takes one byte of the encoded buffer per beat on i_in and
// emits flat tokens on o_out (kind, 64-bit value, last flag per byte). A byte is accepted
// every cycle while the token queue between the decode front and the output stage has
// room (QUEUE_DEPTH entries); the front decides a byte's tokens in the cycle it accepts
// it. The output stage sends one token per cycle while o_out.ready is high, so a byte
// that ends the buffer inside an item yields its own token plus a truncated token, sent in
// turn; sustained input rate is one byte per cycle otherwise, while o_out.ready is high.
// A token enters the queue as its byte is accepted, then the output register. Multi-byte
// fields are big-endian; after an invalid code, bytes are dropped until end_of_buffer.
module msgpack_token_decoder_core #(
    parameter int QUEUE_DEPTH = mtd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtd_in_if.sink     i_in,
    mtd_out_if.source  o_out
);
    import mtd_pkg::*;

    t_entry front_entry, queue_head;
    logic   push, full, pop, empty;

    mtd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    mtd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_head),
        .o_empty (empty)
    );

    mtd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (queue_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* tb/msgpack_token_decoder_core_tb.sv */
`timescale 1ns / 100ps

module msgpack_token_decoder_core_tb;
    import mtd_pkg::*;

    localparam int RANDOM_BYTES = 950;

    // codes the package leaves unnamed
    localparam logic [7:0] C_NEVER_USED = 8'hc1;
    localparam logic [7:0] C_EXT8       = 8'hc7;
    localparam logic [7:0] C_FIXEXT1    = 8'hd4;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic        last;
    } token_t;

    class token_scoreboard;
        t_phase      phase;
        t_kind       pend_kind;
        logic [3:0]  hdr_left;
        logic [63:0] acc;
        logic [31:0] pay_left;
        token_t      step_tokens[$];
        token_t      expected_q[$];
        int          decoded_bytes;
        int          mismatches;

        function new();
            clear_state();
            decoded_bytes = 0;
            mismatches = 0;
        endfunction

        function void clear_state();
            phase = PH_IDLE;
            pend_kind = K_NIL;
            hdr_left = 4'd0;
            acc = 64'd0;
            pay_left = 32'd0;
        endfunction

        function void add_token(t_kind k, logic [63:0] v);
            token_t t;
            t.kind = k;
            t.value = v;
            t.last = 1'b0;
            if (step_tokens.size() < 2) step_tokens.push_back(t);
        endfunction

        function void open_header(t_kind k, logic [3:0] n);
            phase = PH_HEADER;
            pend_kind = k;
            hdr_left = n;
            acc = 64'd0;
        endfunction

        function void open_payload(t_kind k, logic [31:0] len);
            add_token(k, {32'd0, len});
            if (len != 0) begin
                phase = PH_PAYLOAD;
                pay_left = len;
            end else begin
                phase = PH_IDLE;
            end
        endfunction

        function void decode_type(logic [7:0] c);
            if (c <= C_POSFIX_HI) begin
                add_token(K_UINT, {56'd0, c});
            end else if (c <= C_FIXMAP_HI) begin
                add_token(K_MAP, {60'd0, c[3:0]});
            end else if (c <= C_FIXARR_HI) begin
                add_token(K_ARRAY, {60'd0, c[3:0]});
            end else if (c <= C_FIXSTR_HI) begin
                open_payload(K_STR, {27'd0, c[4:0]});
            end else if (c >= C_NEGFIX_LO) begin
                add_token(K_SINT, {56'hff_ffff_ffff_ffff, c});
            end else begin
                case (c)
                    C_NIL:     add_token(K_NIL, 64'd0);
                    C_FALSE:   add_token(K_FALSE, 64'd0);
                    C_TRUE:    add_token(K_TRUE, 64'd0);
                    C_BIN8:    open_header(K_BIN, 4'd1);
                    C_BIN16:   open_header(K_BIN, 4'd2);
                    C_BIN32:   open_header(K_BIN, 4'd4);
                    C_FLOAT32: open_header(K_F32, 4'd4);
                    C_FLOAT64: open_header(K_F64, 4'd8);
                    C_UINT8:   open_header(K_UINT, 4'd1);
                    C_UINT16:  open_header(K_UINT, 4'd2);
                    C_UINT32:  open_header(K_UINT, 4'd4);
                    C_UINT64:  open_header(K_UINT, 4'd8);
                    C_INT8:    open_header(K_SINT_FIRST, 4'd1);
                    C_INT16:   open_header(K_SINT_FIRST, 4'd2);
                    C_INT32:   open_header(K_SINT_FIRST, 4'd4);
                    C_INT64:   open_header(K_SINT_FIRST, 4'd8);
                    C_STR8:    open_header(K_STR, 4'd1);
                    C_STR16:   open_header(K_STR, 4'd2);
                    C_STR32:   open_header(K_STR, 4'd4);
                    C_ARRAY16: open_header(K_ARRAY, 4'd2);
                    C_ARRAY32: open_header(K_ARRAY, 4'd4);
                    C_MAP16:   open_header(K_MAP, 4'd2);
                    C_MAP32:   open_header(K_MAP, 4'd4);
                    default: begin
                        add_token(K_INVALID, 64'd0);
                        phase = PH_ERROR;
                    end
                endcase
            end
        endfunction

        function void take_header_byte(logic [7:0] b);
            // first byte of a signed field picks the sign fill
            if (pend_kind == K_SINT_FIRST) begin
                acc = {64{b[7]}};
                pend_kind = K_SINT;
            end
            acc = {acc[55:0], b};
            if (hdr_left != 0) hdr_left = hdr_left - 4'd1;
            if (hdr_left == 0) begin
                if (pend_kind == K_STR || pend_kind == K_BIN) begin
                    open_payload(pend_kind, acc[31:0]);
                end else begin
                    add_token(pend_kind, acc);
                    phase = PH_IDLE;
                end
            end
        endfunction

        function void note_byte(logic [7:0] b, logic eob);
            token_t t;
            step_tokens.delete();
            if (phase != PH_ERROR) decoded_bytes++;
            case (phase)
                PH_IDLE:   decode_type(b);
                PH_HEADER: take_header_byte(b);
                PH_PAYLOAD: begin
                    add_token(K_PAYLOAD, {56'd0, b});
                    pay_left = pay_left - 32'd1;
                    if (pay_left == 0) phase = PH_IDLE;
                end
                default: ;
            endcase
            if (eob) begin
                if (phase == PH_HEADER || phase == PH_PAYLOAD) add_token(K_TRUNC, 64'd0);
                clear_state();
            end
            for (int i = 0; i < step_tokens.size(); i++) begin
                t = step_tokens[i];
                t.last = (i == step_tokens.size() - 1);
                expected_q.push_back(t);
            end
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        endfunction

        function void check_token(t_kind k, logic [63:0] v, logic l);
            token_t want;
            if (expected_q.size() == 0) begin
                report("token kind (no token expected)", 64'd0, {60'd0, k});
                return;
            end
            want = expected_q.pop_front();
            if (want.kind !== k) report("token_kind", {60'd0, want.kind}, {60'd0, k});
            if (want.value !== v) report("token_value", want.value, v);
            if (want.last !== l) report("last_result", {63'd0, want.last}, {63'd0, l});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtd_in_if  in_if();
    mtd_out_if out_if();

    msgpack_token_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    token_scoreboard sb = new();

    logic [7:0] buf_q[$];
    bit         cut_here;
    int         burst_left = 0;

    // {end_of_buffer, data_byte}
    logic [8:0] directed [28] = '{
        {1'b0, C_POSFIX_LO}, {1'b0, C_POSFIX_HI}, {1'b0, C_FIXMAP_LO}, {1'b0, C_FIXMAP_HI},
        {1'b0, C_FIXARR_LO}, {1'b0, C_FIXARR_HI}, {1'b0, C_NIL},       {1'b0, C_FALSE},
        {1'b0, C_TRUE},      {1'b0, C_NEGFIX_LO}, {1'b0, C_NEGFIX_HI}, {1'b0, C_FIXSTR_LO},
        {1'b0, C_INT8},      {1'b0, 8'h80},       {1'b0, C_UINT8},     {1'b0, 8'hff},
        {1'b0, C_BIN8},      {1'b0, 8'h02},       {1'b0, 8'h00},       {1'b1, 8'hff},
        {1'b0, C_UINT64},    {1'b1, 8'h12},       {1'b0, C_NEVER_USED}, {1'b0, C_FIXEXT1},
        {1'b1, 8'h00},       {1'b0, C_EXT8},      {1'b1, 8'h55},       {1'b1, C_FIXSTR_HI}
    };

    task automatic put_byte(input logic [7:0] b, input logic eob);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 2) != 0) begin
                in_if.valid = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
        end
        burst_left--;
        in_if.valid = 1'b1;
        in_if.data_byte = b;
        in_if.end_of_buffer = eob;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b, eob);
        @(negedge i_clk);
    endtask

    task automatic add_random(input int n);
        repeat (n) buf_q.push_back(8'($urandom));
    endtask

    task automatic add_field(input int n);
        int style;
        style = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            case (style)
                0: buf_q.push_back(8'h00);
                1: buf_q.push_back(8'hff);
                2: buf_q.push_back(i == 0 ? 8'h80 : 8'h00);
                3: buf_q.push_back(i == 0 ? 8'h7f : 8'hff);
                default: buf_q.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic add_item();
        int          r;
        logic [7:0]  c;
        logic [31:0] len;
        bit          wide;
        cut_here = 0;
        r = $urandom_range(0, 3);
        case ($urandom_range(0, 14))
            0: buf_q.push_back(8'($urandom_range(0, 127)));
            1: buf_q.push_back(C_NEGFIX_LO | 8'($urandom_range(0, 31)));
            2: buf_q.push_back(C_FIXMAP_LO | 8'($urandom_range(0, 15)));
            3: buf_q.push_back(C_FIXARR_LO | 8'($urandom_range(0, 15)));
            4: begin
                case ($urandom_range(0, 2))
                    0: buf_q.push_back(C_NIL);
                    1: buf_q.push_back(C_FALSE);
                    default: buf_q.push_back(C_TRUE);
                endcase
            end
            5, 6: begin
                len = $urandom_range(0, 31);
                buf_q.push_back(C_FIXSTR_LO | len[7:0]);
                add_random(len);
            end
            7: begin
                buf_q.push_back(C_UINT8 + 8'(r));
                add_field(1 << r);
            end
            8: begin
                buf_q.push_back(C_INT8 + 8'(r));
                add_field(1 << r);
            end
            9: begin
                if (r[0]) begin
                    buf_q.push_back(C_FLOAT64);
                    add_field(8);
                end else begin
                    buf_q.push_back(C_FLOAT32);
                    add_field(4);
                end
            end
            10: begin
                case (r)
                    0: buf_q.push_back(C_ARRAY16);
                    1: buf_q.push_back(C_MAP16);
                    2: buf_q.push_back(C_ARRAY32);
                    default: buf_q.push_back(C_MAP32);
                endcase
                add_field(r < 2 ? 2 : 4);
            end
            11, 12: begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 12);
                buf_q.push_back(r[0] ? C_BIN8 : C_STR8);
                buf_q.push_back(len[7:0]);
                add_random(len);
            end
            13: begin
                wide = r[1];
                case ($urandom_range(0, 2))
                    0: len = $urandom_range(0, 40);
                    1: len = $urandom;
                    default: len = '1;
                endcase
                if (!wide) len[31:16] = 16'd0;
                if (wide) buf_q.push_back(r[0] ? C_BIN32 : C_STR32);
                else      buf_q.push_back(r[0] ? C_BIN16 : C_STR16);
                if (wide) begin
                    buf_q.push_back(len[31:24]);
                    buf_q.push_back(len[23:16]);
                end
                buf_q.push_back(len[15:8]);
                buf_q.push_back(len[7:0]);
                // long payloads are cut short and the buffer ends inside them
                if (len <= 40) begin
                    add_random(len);
                end else begin
                    add_random($urandom_range(0, 4));
                    cut_here = 1;
                end
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: c = C_NEVER_USED;
                    1: c = C_EXT8 + 8'($urandom_range(0, 2));
                    default: c = C_FIXEXT1 + 8'($urandom_range(0, 4));
                endcase
                buf_q.push_back(c);
                add_random($urandom_range(0, 3));
                cut_here = 1;
            end
        endcase
    endtask

    task automatic run_buffer();
        int n_items;
        int cut_at;
        bit end_it;
        buf_q.delete();
        cut_here = 0;
        if ($urandom_range(0, 15) == 0) begin
            add_random($urandom_range(1, 10));
        end else begin
            n_items = $urandom_range(1, 6);
            for (int i = 0; i < n_items && !cut_here; i++) add_item();
            if ($urandom_range(0, 7) == 0 && buf_q.size() > 1) begin
                cut_at = $urandom_range(1, buf_q.size() - 1);
                while (buf_q.size() > cut_at) void'(buf_q.pop_back());
            end
        end
        // now and then let the next buffer run on without an end marker
        end_it = cut_here || ($urandom_range(0, 9) != 0);
        for (int i = 0; i < buf_q.size(); i++)
            put_byte(buf_q[i], end_it && (i == buf_q.size() - 1));
    endtask

    // receiver stall pattern, reloaded whenever its hold count runs out
    initial begin
        int          hold;
        int          rx_pos;
        logic [15:0] rx_mask;
        hold = 0;
        rx_pos = 0;
        rx_mask = '1;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                hold = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: rx_mask = '1;
                    1: rx_mask = 16'h5555;
                    2: rx_mask = 16'($urandom) | 16'h0001;
                    default: rx_mask = 16'h0101;
                endcase
            end
            hold--;
            out_if.ready = rx_mask[rx_pos % 16];
            rx_pos++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_token(out_if.token_kind, out_if.token_value, out_if.last_result);
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = 8'd0;
        in_if.end_of_buffer = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) put_byte(directed[i][7:0], directed[i][8]);
        while (sb.decoded_bytes < $size(directed) + RANDOM_BYTES) run_buffer();
        in_if.valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
